@@ rtl/cbss_pkg.sv @@
package cbss_pkg;

    localparam int SAMPLE_W = 32;
    localparam int PAD_W    = 10;
    localparam int SCALE_W  = 16;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // register map, byte addresses 4*i
    localparam logic REG_INPUT_PAD  = 1'b0;
    localparam logic REG_SLEW_SCALE = 1'b1;

    localparam logic [PAD_W-1:0]   PAD_RESET   = 10'd1000;
    localparam logic [PAD_W-1:0]   PAD_MAX     = 10'd1000;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;
    localparam logic [SCALE_W-1:0] SCALE_MIN   = 16'd1486;

    // pad target = pad*1073741 + (pad*103 + 62)/125, the division by reciprocal
    localparam logic [30:0] TGT_BASE_MUL = 31'd1073741;
    localparam logic [16:0] TGT_REM_MUL  = 17'd103;
    localparam logic [16:0] TGT_REM_ADD  = 17'd62;
    localparam logic [34:0] TGT_RECIP    = 35'd134218;

    localparam logic [31:0] CHASE_FLOOR = 32'd367001600;
    localparam logic [31:0] CHASE_CAP   = 32'd2621440000;
    localparam logic [31:0] DECAY_MUL   = 32'd4294537799;
    localparam logic [31:0] DECAY_SUB   = 32'd10486;
    localparam logic [43:0] NOISE_MUL   = 44'd3483;
    localparam logic [31:0] DITHER_MUL  = 32'd3924931155;
    localparam logic [6:0]  DITHER_SH   = 7'd86;
    localparam logic [5:0]  LEAD_ZERO   = 6'd27;
    localparam logic [31:0] NOISE_SEED  = 32'h9E3779B9;
    localparam logic [10:0] PAD_NONE    = 11'h7FF;
    localparam logic [32:0] ONE_Q20     = 33'd1048576;
    localparam logic [48:0] SLEW_ONE    = 49'd1099511627776;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TGT,
        OP_DECAY,
        OP_NUM,
        OP_DIVINIT,
        OP_DIV,
        OP_GAIN,
        OP_V,
        OP_SQ,
        OP_CUBE1,
        OP_CUBE2,
        OP_HALF,
        OP_LEAD1,
        OP_LEAD2,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } dp_stat_t;

endpackage

@@ rtl/cbss_regs.sv @@
module cbss_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbss_pkg::ADDR_W-1:0]   paddr,
    input  logic [cbss_pkg::DATA_W-1:0]   pwdata,
    output logic [cbss_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [cbss_pkg::PAD_W-1:0]    input_pad,
    output logic [cbss_pkg::SCALE_W-1:0]  slew_scale
);
    import cbss_pkg::*;

    logic [PAD_W-1:0]   pad_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_reg   <= PAD_RESET;
            scale_reg <= SCALE_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_INPUT_PAD) begin
                pad_reg <= pwdata[PAD_W-1:0];
            end else begin
                scale_reg <= pwdata[SCALE_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_INPUT_PAD) begin
            prdata = DATA_W'(pad_reg);
        end else begin
            prdata = DATA_W'(scale_reg);
        end
    end

    assign input_pad  = pad_reg;
    assign slew_scale = scale_reg;

endmodule

@@ rtl/cbss_ctrl.sv @@
module cbss_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cbss_pkg::dp_stat_t stat,
    output cbss_pkg::dp_cmd_t  cmd
);
    import cbss_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TGT,
        ST_DECAY,
        ST_NUM,
        ST_DIVINIT,
        ST_DIV,
        ST_GAIN,
        ST_V,
        ST_SQ,
        ST_CUBE1,
        ST_CUBE2,
        ST_HALF,
        ST_LEAD1,
        ST_LEAD2,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_TGT;
                end
            end
            ST_TGT:     begin cmd.op = OP_TGT;     state_next = ST_DECAY;   end
            ST_DECAY:   begin cmd.op = OP_DECAY;   state_next = ST_NUM;     end
            ST_NUM:     begin cmd.op = OP_NUM;     state_next = ST_DIVINIT; end
            ST_DIVINIT: begin cmd.op = OP_DIVINIT; state_next = ST_DIV;     end
            ST_DIV: begin
                cmd.op = OP_DIV;
                if (stat.div_last) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:    begin cmd.op = OP_GAIN;    state_next = ST_V;       end
            ST_V:       begin cmd.op = OP_V;       state_next = ST_SQ;      end
            ST_SQ:      begin cmd.op = OP_SQ;      state_next = ST_CUBE1;   end
            ST_CUBE1:   begin cmd.op = OP_CUBE1;   state_next = ST_CUBE2;   end
            ST_CUBE2:   begin cmd.op = OP_CUBE2;   state_next = ST_HALF;    end
            ST_HALF:    begin cmd.op = OP_HALF;    state_next = ST_LEAD1;   end
            ST_LEAD1:   begin cmd.op = OP_LEAD1;   state_next = ST_LEAD2;   end
            ST_LEAD2:   begin cmd.op = OP_LEAD2;   state_next = ST_OUT;     end
            ST_OUT: begin
                cmd.op = OP_OUT;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

@@ rtl/cbss_dp.sv @@
module cbss_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  cbss_pkg::dp_cmd_t                    cmd,
    output cbss_pkg::dp_stat_t                   stat,
    input  logic [cbss_pkg::PAD_W-1:0]           input_pad,
    input  logic [cbss_pkg::SCALE_W-1:0]         slew_scale,
    input  logic signed [cbss_pkg::SAMPLE_W-1:0] s_sample_in,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic signed [cbss_pkg::SAMPLE_W-1:0] m_sample_out
);
    import cbss_pkg::*;

    // state with reset values
    logic [31:0]        chase_reg, chase_next;
    logic [10:0]        seen_reg, seen_next;
    logic               gvalid_reg, gvalid_next;
    logic [31:0]        gain_reg, gain_next;
    logic signed [31:0] prev_reg, prev_next;
    logic [31:0]        noise_reg, noise_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               mvalid_reg, mvalid_next;

    // working registers
    logic signed [31:0] x_reg, x_next;
    logic [PAD_W-1:0]   padc_reg, padc_next;
    logic [16:0]        n_reg, n_next;
    logic [30:0]        base_reg, base_next;
    logic [30:0]        tgt_reg, tgt_next;
    logic [63:0]        prod_reg, prod_next;
    logic [32:0]        rem_reg, rem_next;
    logic [31:0]        q_reg, q_next;
    logic signed [31:0] v_reg, v_next;
    logic [48:0]        s_reg, s_next;
    logic [50:0]        p1_reg, p1_next;
    logic [50:0]        p2_reg, p2_next;
    logic [24:0]        f_reg, f_next;
    logic [38:0]        cube_reg, cube_next;
    logic signed [40:0] y_reg, y_next;
    logic [4:0]         bnz_reg, bnz_next;
    logic [4:0][2:0]    bpos_reg, bpos_next;
    logic [63:0]        dm_reg, dm_next;
    logic               dneg_reg, dneg_next;
    logic signed [17:0] dith_reg, dith_next;
    logic signed [31:0] out_reg, out_next;

    // combinational helpers
    logic [PAD_W-1:0]   pad_clamp;
    logic [SCALE_W-1:0] scale_clamp;
    logic [43:0]        zmul;
    logic [34:0]        tmul;
    logic [32:0]        dbl;
    logic [31:0]        c0, c1, c2;
    logic [32:0]        den;
    logic [64:0]        num;
    logic [33:0]        trial;
    logic [31:0]        ax, av;
    logic [63:0]        round_a;
    logic [33:0]        amag;
    logic signed [32:0] dv;
    logic [32:0]        diff;
    logic [62:0]        round_sq;
    logic [34:0]        sq;
    logic [48:0]        s_cap;
    logic [50:0]        csum;
    logic [63:0]        hmul;
    logic [39:0]        half;
    logic [39:0]        ay;
    logic [31:0]        n1, n2, n3;
    logic signed [32:0] d;
    logic [31:0]        dmag;
    logic [5:0]         lead;
    logic [6:0]         sh;
    logic [63:0]        dsh;
    logic [16:0]        dith_mag;
    logic signed [41:0] r;
    logic               out_free;

    assign out_free      = !mvalid_reg || m_ready;
    assign stat.out_free = out_free;
    assign stat.div_last = (cnt_reg == 5'd31);
    assign m_valid       = mvalid_reg;
    assign m_sample_out  = out_reg;

    always_comb begin
        chase_next  = chase_reg;
        seen_next   = seen_reg;
        gvalid_next = gvalid_reg;
        gain_next   = gain_reg;
        prev_next   = prev_reg;
        noise_next  = noise_reg;
        cnt_next    = cnt_reg;
        x_next      = x_reg;
        padc_next   = padc_reg;
        n_next      = n_reg;
        base_next   = base_reg;
        tgt_next    = tgt_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        v_next      = v_reg;
        s_next      = s_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        f_next      = f_reg;
        cube_next   = cube_reg;
        y_next      = y_reg;
        bnz_next    = bnz_reg;
        bpos_next   = bpos_reg;
        dm_next     = dm_reg;
        dneg_next   = dneg_reg;
        dith_next   = dith_reg;
        out_next    = out_reg;

        pad_clamp   = (input_pad > PAD_MAX) ? PAD_MAX : input_pad;
        scale_clamp = (slew_scale < SCALE_MIN) ? SCALE_MIN : slew_scale;
        zmul        = 44'(noise_reg) * NOISE_MUL;
        tmul        = 35'(n_reg) * TGT_RECIP;
        dbl         = {chase_reg, 1'b0};
        c0          = prod_reg[63:32];
        c1          = (c0 < DECAY_SUB) ? 32'd0 : c0 - DECAY_SUB;
        c2          = (c1 < CHASE_FLOOR) ? CHASE_FLOOR : c1;
        den         = {1'b0, chase_reg} + ONE_Q20;
        num         = 65'(prod_reg) + (65'(tgt_reg) << 20) + 65'(den >> 1);
        trial       = {rem_reg, q_reg[31]};
        ax          = x_reg[31] ? 32'(-x_reg) : 32'(x_reg);
        av          = v_reg[31] ? 32'(-v_reg) : 32'(v_reg);
        round_a     = prod_reg + 64'd536870912;
        amag        = round_a[63:30];
        dv          = 33'(v_reg) - 33'(prev_reg);
        diff        = dv[32] ? 33'(-dv) : 33'(dv);
        round_sq    = prod_reg[62:0] + 63'd134217728;
        sq          = round_sq[62:28];
        s_cap       = (s_reg > SLEW_ONE) ? SLEW_ONE : s_reg;
        csum        = p1_reg + (p2_reg >> 16);
        hmul        = 64'(cube_reg) * 64'(f_reg);
        half        = hmul[63:24];
        ay          = y_reg[40] ? 40'(-y_reg) : 40'(y_reg);
        n1          = noise_reg ^ (noise_reg << 13);
        n2          = n1 ^ (n1 >> 17);
        n3          = n2 ^ (n2 << 5);
        d           = $signed({1'b0, n3}) - 33'sh07FFFFFFF;
        dmag        = d[32] ? 32'(-d) : 32'(d);
        lead        = LEAD_ZERO;
        for (int i = 0; i < 5; i++) begin
            if (bnz_reg[i]) begin
                lead = 6'(i * 8) + 6'(bpos_reg[i]);
            end
        end
        sh       = DITHER_SH - 7'(lead);
        dsh      = dm_reg >> sh[5:0];
        dith_mag = sh[6] ? 17'd0 : dsh[16:0];
        r        = 42'(y_reg) + 42'(dith_reg);

        case (cmd.op)
            OP_LOAD: begin
                x_next    = (s_sample_in == 32'sd0) ? $signed({28'd0, zmul[43:40]})
                                                     : s_sample_in;
                padc_next = pad_clamp;
                n_next    = 17'(pad_clamp) * TGT_REM_MUL + TGT_REM_ADD;
                base_next = 31'(pad_clamp) * TGT_BASE_MUL;
            end
            OP_TGT: begin
                tgt_next = base_reg + 31'(tmul >> 24);
                if ({1'b0, padc_reg} != seen_reg) begin
                    chase_next = (dbl > 33'(CHASE_CAP)) ? CHASE_CAP : dbl[31:0];
                    seen_next  = {1'b0, padc_reg};
                end else begin
                    chase_next = (chase_reg > CHASE_CAP) ? CHASE_CAP : chase_reg;
                end
            end
            OP_DECAY: begin
                if (!gvalid_reg) begin
                    gain_next   = 32'(tgt_reg);
                    gvalid_next = 1'b1;
                end
                prod_next = 64'(chase_reg) * 64'(DECAY_MUL);
            end
            OP_NUM: begin
                chase_next = c2;
                prod_next  = 64'(gain_reg) * 64'(c2);
            end
            OP_DIVINIT: begin
                rem_next = num[64:32];
                q_next   = num[31:0];
                cnt_next = 5'd0;
            end
            OP_DIV: begin
                if (trial >= {1'b0, den}) begin
                    rem_next = 33'(trial - {1'b0, den});
                    q_next   = {q_reg[30:0], 1'b1};
                end else begin
                    rem_next = trial[32:0];
                    q_next   = {q_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
            end
            OP_GAIN: begin
                gain_next = q_reg;
                prod_next = 64'(ax) * 64'(q_reg);
            end
            OP_V: begin
                if (x_reg[31]) begin
                    v_next = (amag >= 34'd2147483648) ? 32'sh80000000
                                                      : 32'(-$signed({1'b0, amag}));
                end else begin
                    v_next = (amag > 34'd2147483647) ? 32'sh7FFFFFFF : $signed(amag[31:0]);
                end
            end
            OP_SQ: begin
                prod_next = 64'(av) * 64'(av);
                s_next    = 49'(diff) * 49'(scale_clamp);
                prev_next = v_reg;
            end
            OP_CUBE1: begin
                p1_next = 51'(sq) * 51'(av[31:16]);
                p2_next = 51'(sq) * 51'(av[15:0]);
                f_next  = 25'((SLEW_ONE - s_cap) >> 16);
            end
            OP_CUBE2: begin
                cube_next = 39'(csum >> 12);
            end
            OP_HALF: begin
                if (v_reg[31]) begin
                    y_next = 41'(v_reg) - $signed({1'b0, half});
                end else begin
                    y_next = 41'(v_reg) + $signed({1'b0, half});
                end
            end
            OP_LEAD1: begin
                for (int i = 0; i < 5; i++) begin
                    bnz_next[i]  = |ay[i*8 +: 8];
                    bpos_next[i] = 3'd0;
                    for (int b = 0; b < 8; b++) begin
                        if (ay[i*8 + b]) begin
                            bpos_next[i] = 3'(b);
                        end
                    end
                end
                noise_next = n3;
                dneg_next  = d[32];
                dm_next    = 64'(dmag) * 64'(DITHER_MUL);
            end
            OP_LEAD2: begin
                dith_next = dneg_reg ? -$signed({1'b0, dith_mag}) : $signed({1'b0, dith_mag});
            end
            OP_OUT: begin
                if (r > 42'sd2147483647) begin
                    out_next = 32'sh7FFFFFFF;
                end else if (r < -42'sd2147483648) begin
                    out_next = 32'sh80000000;
                end else begin
                    out_next = r[31:0];
                end
            end
            default: ;
        endcase

        if (cmd.op == OP_OUT && out_free) begin
            mvalid_next = 1'b1;
        end else if (m_ready) begin
            mvalid_next = 1'b0;
        end else begin
            mvalid_next = mvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chase_reg  <= CHASE_FLOOR;
            seen_reg   <= PAD_NONE;
            gvalid_reg <= 1'b0;
            gain_reg   <= 32'd0;
            prev_reg   <= 32'sd0;
            noise_reg  <= NOISE_SEED;
            cnt_reg    <= 5'd0;
            mvalid_reg <= 1'b0;
        end else begin
            chase_reg  <= chase_next;
            seen_reg   <= seen_next;
            gvalid_reg <= gvalid_next;
            gain_reg   <= gain_next;
            prev_reg   <= prev_next;
            noise_reg  <= noise_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // output beat only loads while the output register is free
    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        padc_reg <= padc_next;
        n_reg    <= n_next;
        base_reg <= base_next;
        tgt_reg  <= tgt_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        v_reg    <= v_next;
        s_reg    <= s_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        f_reg    <= f_next;
        cube_reg <= cube_next;
        y_reg    <= y_next;
        bnz_reg  <= bnz_next;
        bpos_reg <= bpos_next;
        dm_reg   <= dm_next;
        dneg_reg <= dneg_next;
        dith_reg <= dith_next;
        if (cmd.op == OP_OUT && out_free) begin
            out_reg <= out_next;
        end
    end

endmodule

@@ rtl/console_buss_sample_shaper.sv @@
// Console buss sample shaper: one signed Q3.28 sample in, one shaped and
// dithered sample out. Each beat steps through the controller states in
// order; in the restoring divider among them, which updates the smoothed
// gain, one quotient bit is found per cycle. Samples are handled one at a
// time; a finished result waits in the output register while the next
// sample is accepted.
// Registers on the APB port: input_pad at 0x0, slew_scale at 0x4.
module console_buss_sample_shaper (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [cbss_pkg::ADDR_W-1:0]          paddr,
    input  logic [cbss_pkg::DATA_W-1:0]          pwdata,
    output logic [cbss_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [cbss_pkg::SAMPLE_W-1:0] s_sample_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [cbss_pkg::SAMPLE_W-1:0] m_sample_out
);
    import cbss_pkg::*;

    logic [PAD_W-1:0]   input_pad;
    logic [SCALE_W-1:0] slew_scale;
    dp_cmd_t            cmd;
    dp_stat_t           stat;

    cbss_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .input_pad  (input_pad),
        .slew_scale (slew_scale)
    );

    cbss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cbss_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .input_pad    (input_pad),
        .slew_scale   (slew_scale),
        .s_sample_in  (s_sample_in),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_sample_out (m_sample_out)
    );

endmodule
